@@ rtl/core/egcd_pkg.sv @@
package egcd_pkg;

  // operand, coefficient output and shift count widths
  localparam int OPND_W       = 31;
  localparam int COEF_W       = 32;
  localparam int CMP_W        = OPND_W + 1;
  localparam int CNT_W        = 5;
  localparam int EXT_W        = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // input item
  typedef struct packed {
    logic [OPND_W-1:0] value_a;
    logic [OPND_W-1:0] value_b;
  } in_t;

  // result item
  typedef struct packed {
    logic [OPND_W-1:0]        gcd_value;
    logic signed [COEF_W-1:0] coeff_a;
    logic signed [COEF_W-1:0] coeff_b;
  } out_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ALIGN,
    ST_SUB
  } state_t;

  // requests from the top level to the sequencer
  typedef struct packed {
    logic start;
    logic res_free;
  } seq_ctl_t;

  // status from the sequencer to the top level
  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

endpackage

@@ rtl/core/egcd_unit.sv @@
module egcd_unit #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
  input  logic [egcd_pkg::OPND_W-1:0] rem,
  input  logic [egcd_pkg::CMP_W-1:0]  opnd,
  input  logic [egcd_pkg::CNT_W-1:0]  cnt,
  input  logic [DATA_WIDTH-1:0]       u0,
  input  logic [DATA_WIDTH-1:0]       v0,
  input  logic [DATA_WIDTH-1:0]       u1,
  input  logic [DATA_WIDTH-1:0]       v1,
  output logic                        take,
  output logic [egcd_pkg::OPND_W-1:0] rem_diff,
  output logic [DATA_WIDTH-1:0]       u_diff,
  output logic [DATA_WIDTH-1:0]       v_diff
);

  logic [DATA_WIDTH-1:0] u1_sh;
  logic [DATA_WIDTH-1:0] v1_sh;

  // shared compare and remainder subtract
  assign take     = {1'b0, rem} >= opnd;
  assign rem_diff = rem - opnd[egcd_pkg::OPND_W-1:0];

  // one quotient bit worth of coefficient update, wraps modulo 2^DATA_WIDTH
  assign u1_sh  = u1 << cnt;
  assign v1_sh  = v1 << cnt;
  assign u_diff = u0 - u1_sh;
  assign v_diff = v0 - v1_sh;

endmodule

@@ rtl/core/egcd_seq.sv @@
module egcd_seq #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  egcd_pkg::seq_ctl_t  ctl,
  input  egcd_pkg::in_t       opnds,
  output egcd_pkg::seq_stat_t stat,
  output egcd_pkg::out_t      result
);

  egcd_pkg::state_t state;
  egcd_pkg::state_t state_next;

  logic [egcd_pkg::OPND_W-1:0] r0;
  logic [egcd_pkg::OPND_W-1:0] r1;
  logic [egcd_pkg::OPND_W-1:0] dsh;
  logic [egcd_pkg::CNT_W-1:0]  cnt;
  logic [DATA_WIDTH-1:0]       u0;
  logic [DATA_WIDTH-1:0]       v0;
  logic [DATA_WIDTH-1:0]       u1;
  logic [DATA_WIDTH-1:0]       v1;

  logic [egcd_pkg::CMP_W-1:0]  opnd;
  logic                        take;
  logic [egcd_pkg::OPND_W-1:0] rem_diff;
  logic [DATA_WIDTH-1:0]       u_diff;
  logic [DATA_WIDTH-1:0]       v_diff;
  logic [egcd_pkg::OPND_W-1:0] rem_after;
  logic [DATA_WIDTH-1:0]       u_after;
  logic [DATA_WIDTH-1:0]       v_after;
  logic [egcd_pkg::EXT_W-1:0]  u_ext;
  logic [egcd_pkg::EXT_W-1:0]  v_ext;

  logic r1_zero;
  logic ld_start;
  logic ld_div;
  logic ld_shift;
  logic ld_step;
  logic ld_swap;

  // doubled divisor while aligning, aligned divisor while subtracting
  always_comb begin
    if (state == egcd_pkg::ST_ALIGN) begin
      opnd = {dsh, 1'b0};
    end else begin
      opnd = {1'b0, dsh};
    end
  end

  egcd_unit #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_unit (
    .rem     (r0),
    .opnd    (opnd),
    .cnt     (cnt),
    .u0      (u0),
    .v0      (v0),
    .u1      (u1),
    .v1      (v1),
    .take    (take),
    .rem_diff(rem_diff),
    .u_diff  (u_diff),
    .v_diff  (v_diff)
  );

  assign r1_zero   = (r1 == '0);
  assign rem_after = take ? rem_diff : r0;
  assign u_after   = take ? u_diff : u0;
  assign v_after   = take ? v_diff : v0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      egcd_pkg::ST_IDLE: begin
        if (ctl.start) begin
          state_next = egcd_pkg::ST_CHECK;
        end
      end
      egcd_pkg::ST_CHECK: begin
        if (!r1_zero) begin
          state_next = egcd_pkg::ST_ALIGN;
        end else if (ctl.res_free) begin
          state_next = egcd_pkg::ST_IDLE;
        end
      end
      egcd_pkg::ST_ALIGN: begin
        if (!take) begin
          state_next = egcd_pkg::ST_SUB;
        end
      end
      egcd_pkg::ST_SUB: begin
        if (cnt == '0) begin
          state_next = egcd_pkg::ST_CHECK;
        end
      end
      default: begin
        state_next = egcd_pkg::ST_IDLE;
      end
    endcase
  end

  // register load controls and status
  always_comb begin
    ld_start  = 1'b0;
    ld_div    = 1'b0;
    ld_shift  = 1'b0;
    ld_step   = 1'b0;
    ld_swap   = 1'b0;
    stat.done = 1'b0;
    stat.busy = (state != egcd_pkg::ST_IDLE);
    case (state)
      egcd_pkg::ST_IDLE: begin
        ld_start = ctl.start;
      end
      egcd_pkg::ST_CHECK: begin
        ld_div    = !r1_zero;
        stat.done = r1_zero && ctl.res_free;
      end
      egcd_pkg::ST_ALIGN: begin
        ld_shift = take;
      end
      egcd_pkg::ST_SUB: begin
        ld_step = (cnt != '0);
        ld_swap = (cnt == '0);
      end
      default: begin
        ld_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= egcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // remainder and coefficient registers
  always_ff @(posedge clk) begin
    if (ld_start) begin
      r0 <= opnds.value_a;
      r1 <= opnds.value_b;
      u0 <= DATA_WIDTH'(1);
      v0 <= '0;
      u1 <= '0;
      v1 <= DATA_WIDTH'(1);
    end
    if (ld_div) begin
      dsh <= r1;
      cnt <= '0;
    end
    if (ld_shift) begin
      dsh <= opnd[egcd_pkg::OPND_W-1:0];
      cnt <= cnt + 1'b1;
    end
    if (ld_step) begin
      r0  <= rem_after;
      u0  <= u_after;
      v0  <= v_after;
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
    end
    if (ld_swap) begin
      r0 <= r1;
      r1 <= rem_after;
      u0 <= u1;
      v0 <= v1;
      u1 <= u_after;
      v1 <= v_after;
    end
  end

  // coefficients sign-extended, then cut to the output width
  assign u_ext = egcd_pkg::EXT_W'($signed(u0));
  assign v_ext = egcd_pkg::EXT_W'($signed(v0));

  assign result.gcd_value = r0;
  assign result.coeff_a   = $signed(u_ext[egcd_pkg::COEF_W-1:0]);
  assign result.coeff_b   = $signed(v_ext[egcd_pkg::COEF_W-1:0]);

  // a start always leads to the zero test of the new pair
  a_start_check: assert property (@(posedge clk) disable iff (rst)
    ctl.start && state == egcd_pkg::ST_IDLE |=> state == egcd_pkg::ST_CHECK)
    else $error("start did not reach the zero test");

  // the aligned divisor is always the divisor shifted by the count
  a_align_shift: assert property (@(posedge clk) disable iff (rst)
    (state == egcd_pkg::ST_ALIGN || state == egcd_pkg::ST_SUB) |->
      ((dsh >> cnt) == r1))
    else $error("aligned divisor lost track of the divisor");

  // done only when the remainder pair has run out
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (state == egcd_pkg::ST_CHECK && r1_zero))
    else $error("done raised before the remainder reached zero");

  // the divisor never aligns past the dividend
  a_align_bound: assert property (@(posedge clk) disable iff (rst)
    (state == egcd_pkg::ST_ALIGN) |-> (dsh <= r0 || cnt == '0))
    else $error("divisor aligned past the dividend");

  // partial remainder stays below twice the aligned divisor
  a_sub_bound: assert property (@(posedge clk) disable iff (rst)
    (state == egcd_pkg::ST_SUB) |-> ({1'b0, r0} < {dsh, 1'b0}))
    else $error("partial remainder outgrew the aligned divisor");

endmodule

@@ rtl/core/extended_gcd_bezout.sv @@
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+-------------------------------------
// in      | input     | in_valid / in_stall   | in_data: value_a, value_b
// out     | output    | out_valid / out_stall | out_data: gcd_value, coeff_a, coeff_b
//
// one item at a time through a shared compare/subtract and shift/subtract unit.
// each Euclid step doubles the divisor while its double does not exceed the
// remainder, then subtracts it while halving it back; a zero value_b goes
// straight to the output.
// reset clears the sequencer and the output valid; data registers are not reset.
// in_stall is high while an item is in work; a finished item waits in the output
// register, and the next item may be accepted while it waits.
module extended_gcd_bezout #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  egcd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output egcd_pkg::out_t out_data
);

  egcd_pkg::seq_ctl_t  ctl;
  egcd_pkg::seq_stat_t stat;
  egcd_pkg::out_t      result;

  // input accept and output register space
  assign in_stall     = stat.busy;
  assign ctl.start    = in_valid && !stat.busy;
  assign ctl.res_free = !out_valid || !out_stall;

  egcd_seq #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .opnds (in_data),
    .stat  (stat),
    .result(result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_data <= result;
    end
  end

endmodule
